// File: hdl/gbs_pkg.sv
// Shared types, constants and arithmetic helpers of the bilinear grid sampler.
package gbs_pkg;

    // Opcode values carried in the input tuser field
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Reset value of the scale register: 1.0 in unsigned Q4.12
    localparam logic [15:0] SCALE_RESET = 16'd4096;

    // Widest grid index and grid address over the supported grid widths
    localparam int IDX_W  = 8;
    localparam int ADDR_W = 16;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified command as it travels from front to back
    typedef struct packed {
        logic                    is_write;
        logic                    wr_ok;
        logic [ADDR_W-1:0]       addr;
        logic signed [15:0]      value;
        logic [IDX_W-1:0]        x1;
        logic [IDX_W-1:0]        x2;
        logic [IDX_W-1:0]        y1;
        logic [IDX_W-1:0]        y2;
        logic [7:0]              fx;
        logic [7:0]              fy;
    } t_cmd;

    // a + floor(f * (b - a) / 256); the result always lies between a and b
    function automatic logic signed [15:0] lerp8(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic [7:0]         f
    );
        logic signed [16:0] diff;
        logic signed [25:0] prod;
        diff = 17'(b) - 17'(a);
        prod = diff * $signed({1'b0, f});
        return a + 16'(prod >>> 8);
    endfunction

endpackage

// File: hdl/gbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: hdl/gbs_front.sv
// Front end: input stage, scale register, coordinate scaling and cell clamping.
module gbs_front #(
    parameter int GRID_WIDTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data,
    // Input stream
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic          i_op,
    input  logic [11:0]   i_entry_index,
    input  logic [15:0]   i_entry_value,
    input  logic [19:0]   i_pos_x,
    input  logic [19:0]   i_pos_y,
    // Back end status and queue
    input  logic          i_clearing,
    input  logic          i_q_full,
    output logic          o_q_push,
    output gbs_pkg::t_cmd o_q_data
);
    import gbs_pkg::*;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_WIDTH;
    localparam int LAST       = GRID_WIDTH - 1;

    logic [15:0]   r_scale_inv;
    logic          r_valid;
    logic          r_op;
    logic [11:0]   r_idx;
    logic [15:0]   r_val;
    logic [19:0]   r_px;
    logic [19:0]   r_py;
    logic          accept;
    logic [35:0]   prod_x;
    logic [35:0]   prod_y;
    logic [15:0]   cell_x;
    logic [15:0]   cell_y;

    // Scale register, always ready for a write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_inv <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale_inv <= i_cfg_data;
        end
    end

    // Take an item when no grid clear runs and the stage is empty or drains into the queue this cycle
    assign o_q_push = r_valid && !i_q_full;
    assign o_tready = !i_clearing && (!r_valid || !i_q_full);
    assign accept   = i_tvalid && o_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_idx <= i_entry_index;
            r_val <= i_entry_value;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
        end
    end

    // Scale to grid units with 8 fraction bits
    assign prod_x = 36'(r_px) * 36'(r_scale_inv);
    assign prod_y = 36'(r_py) * 36'(r_scale_inv);
    assign cell_x = prod_x[35:20];
    assign cell_y = prod_y[35:20];

    // Classify and clamp the neighbouring cell indices
    always_comb begin
        o_q_data          = '0;
        o_q_data.is_write = (r_op == OP_WRITE);
        o_q_data.wr_ok    = (32'(r_idx) < CELL_COUNT);
        o_q_data.addr     = ADDR_W'(r_idx);
        o_q_data.value    = $signed(r_val);
        o_q_data.fx       = prod_x[19:12];
        o_q_data.fy       = prod_y[19:12];
        o_q_data.x1 = (cell_x > 16'(LAST))  ? IDX_W'(LAST) : cell_x[IDX_W-1:0];
        o_q_data.x2 = (cell_x >= 16'(LAST)) ? IDX_W'(LAST) : cell_x[IDX_W-1:0] + 1'b1;
        o_q_data.y1 = (cell_y > 16'(LAST))  ? IDX_W'(LAST) : cell_y[IDX_W-1:0];
        o_q_data.y2 = (cell_y >= 16'(LAST)) ? IDX_W'(LAST) : cell_y[IDX_W-1:0] + 1'b1;
    end

endmodule

// File: hdl/gbs_queue.sv
// Short command queue between the front end and the back end.
module gbs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gbs_pkg::t_cmd i_data,
    input  logic          i_pop,
    output gbs_pkg::t_cmd o_data,
    output logic          o_empty,
    output logic          o_full
);
    import gbs_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

// File: hdl/gbs_back.sv
// Back end: grid clearing, grid writes, four-cell fetch and interpolation.
module gbs_back #(
    parameter int GRID_WIDTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Queue head
    input  logic          i_q_empty,
    input  gbs_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    // Status to the front end
    output logic          o_clearing,
    // Result stream
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [15:0]   o_sample
);
    import gbs_pkg::*;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_WIDTH;
    localparam int AW         = $clog2(CELL_COUNT);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_ROWS  = 5'b01000,
        S_COL   = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      n_clr_addr;
    logic [2:0]         r_rd_cnt;
    logic [2:0]         n_rd_cnt;
    logic signed [15:0] r_cell [4];
    logic signed [15:0] r_top;
    logic signed [15:0] r_bot;
    logic [15:0]        r_out;
    logic               r_out_valid;
    logic               out_load;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [15:0]        wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [15:0]        rd_data;
    logic [IDX_W-1:0]   rd_row;
    logic [IDX_W-1:0]   rd_col;

    gbs_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_clearing = (r_state == S_CLEAR);
    assign o_tvalid   = r_out_valid;
    assign o_sample   = r_out;
    assign out_load   = (r_state == S_COL) && (!r_out_valid || i_tready);

    // Pick the cell for this fetch: top-left, top-right, bottom-left, bottom-right
    assign rd_row  = r_rd_cnt[1] ? i_q_data.y2 : i_q_data.y1;
    assign rd_col  = r_rd_cnt[0] ? i_q_data.x2 : i_q_data.x1;
    assign rd_addr = AW'(rd_row) * AW'(GRID_WIDTH) + AW'(rd_col);

    // Sequence clearing, writes and samples
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_rd_cnt   = r_rd_cnt;
        wr_en      = 1'b0;
        wr_addr    = r_clr_addr;
        wr_data    = '0;
        rd_en      = 1'b0;
        o_q_pop    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_data.is_write) begin
                        wr_en   = i_q_data.wr_ok;
                        wr_addr = AW'(i_q_data.addr);
                        wr_data = i_q_data.value;
                        o_q_pop = 1'b1;
                    end else begin
                        n_rd_cnt = '0;
                        n_state  = S_READ;
                    end
                end
            end
            S_READ: begin
                rd_en    = !r_rd_cnt[2];
                n_rd_cnt = r_rd_cnt + 1'b1;
                if (r_rd_cnt[2]) begin
                    n_state = S_ROWS;
                end
            end
            S_ROWS: begin
                n_state = S_COL;
            end
            S_COL: begin
                if (out_load) begin
                    o_q_pop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rd_cnt    <= n_rd_cnt;
            r_out_valid <= out_load || (r_out_valid && !i_tready);
        end
    end

    // Shift in each fetched cell in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && r_rd_cnt != '0) begin
            r_cell[0] <= r_cell[1];
            r_cell[1] <= r_cell[2];
            r_cell[2] <= r_cell[3];
            r_cell[3] <= $signed(rd_data);
        end
    end

    // Interpolate both rows along x, then the column along y
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROWS) begin
            r_top <= lerp8(r_cell[0], r_cell[1], i_q_data.fx);
            r_bot <= lerp8(r_cell[2], r_cell[3], i_q_data.fx);
        end
        if (out_load) begin
            r_out <= lerp8(r_top, r_bot, i_q_data.fy);
        end
    end

    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result shown during grid clear");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("finished sample not presented");

    a_sample_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && !i_q_data.is_write) |-> (r_state == S_COL))
        else $error("sample command dropped before its result");

endmodule

// File: hdl/grid_bilinear_sampler.sv
// Top level of the bilinear grid sampler: front end, command queue and back end.
//
// Holds a GRID_WIDTH x GRID_WIDTH grid of signed Q8.8 values. Each transaction on
// the s_axis side carries tuser = opcode (0 write entry, 1 sample) and tdata with
// entry_index, entry_value, pos_x and pos_y. A write stores one entry and gives
// nothing; a sample returns one bilinearly interpolated Q8.8 value on m_axis.
// The scale register (unsigned Q4.12) is written over the cfg channel, which is
// always ready; write it only while the block is idle.
// After reset the grid is swept to zero, one entry per cycle, over all
// GRID_WIDTH*GRID_WIDTH entries (4096 at the default width); s_axis_tready stays
// low until the sweep ends.
// A write is handled in the back-end idle state alone; a sample goes through idle,
// four reads on the single grid RAM read port plus a drain step, then the row and
// column steps. An accepted sample passes the input stage and the queue before
// the back end, and its result reaches m_axis_tvalid through the output register.
// Results wait in an output register when m_axis_tready is low; the queue
// keeps accepting items until it and the input stage are full.
module grid_bilinear_sampler #(
    parameter int GRID_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write: scale_inv
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // entry_index[11:0], entry_value[27:12],
                                       // pos_x[47:28], pos_y[67:48], zero[71:68]
    input  logic        s_axis_tuser,  // opcode[0]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // sample_value[15:0]
);
    import gbs_pkg::*;

    logic clearing;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    t_cmd q_in;
    t_cmd q_out;

    gbs_front #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_tvalid      (s_axis_tvalid),
        .o_tready      (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_entry_index (s_axis_tdata[11:0]),
        .i_entry_value (s_axis_tdata[27:12]),
        .i_pos_x       (s_axis_tdata[47:28]),
        .i_pos_y       (s_axis_tdata[67:48]),
        .i_clearing    (clearing),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    gbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    gbs_back #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_sample   (m_axis_tdata)
    );

endmodule
